// ===== hdl/qnbs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qnbs_pkg
// Shared types and constants of the quadtree node bit serializer.
// ----------------------------------------------------------------------------
package qnbs_pkg;

  localparam int ByteBits    = 8;
  localparam int ErrorBits   = 2;
  localparam int AccBits     = ByteBits - 1;
  localparam int FieldBits   = ByteBits + ErrorBits + 1;
  localparam int CombBits    = AccBits + FieldBits;
  localparam int MaxBytes    = 3;
  localparam int AlignBits   = MaxBytes * ByteBits;
  localparam int TotalBits   = $clog2(CombBits + 1);
  localparam int CountBits   = $clog2(ByteBits);
  localparam int LevelBits   = $clog2(MaxBytes + 1);

  localparam logic [1:0] LastSibling = 2'd3;

  typedef enum logic [1:0] {
    KIND_ROOT     = 2'd0,
    KIND_INTERIOR = 2'd1,
    KIND_FINEST   = 2'd2
  } node_kind_t;

  typedef struct packed {
    logic [1:0] node_kind;
    logic [1:0] sibling_pos;
    logic       parent_collapsed;
    logic [7:0] mean_value;
    logic [1:0] node_error;
    logic       uniform_flag;
    logic       end_of_image;
  } node_t;

  typedef struct packed {
    logic [AccBits-1:0]   bit_accumulator;
    logic [CountBits-1:0] bit_count;
    logic                 stream_done;
  } pack_state_t;

  typedef struct packed {
    logic [LevelBits-1:0]               count;
    logic [MaxBytes-1:0][ByteBits-1:0]  bytes;
    logic                               last;
  } pack_result_t;

  typedef struct packed {
    logic [LevelBits-1:0] level;
    logic                 can_load;
  } outq_status_t;

endpackage

// ===== hdl/quadtree_node_bit_serializer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadtree_node_bit_serializer_top
// Packs level-ordered quadtree nodes into an MSB-first byte stream.
// ----------------------------------------------------------------------------
// Feed nodes in level order, one per transaction; bytes of the code stream
// come out MSB first, and last_byte marks the final (zero-padded) byte of an
// image. A node is packed in the cycle it is accepted and all of its bytes
// (zero to three) are loaded into a small output queue at once. The input
// is ready whenever that queue is empty or is handing out its final byte,
// so a node that yields two or three bytes holds the input until the queue
// hands out its final byte, while nodes that yield no byte or one byte stream
// at one per cycle as long as the output is taken every cycle. A uniform root
// with error 0 ends the image early: waiting bits are flushed and later nodes
// are dropped up to and including the node flagged end_of_image. No clearing
// pass is needed after reset.
// ----------------------------------------------------------------------------
module quadtree_node_bit_serializer_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] node_kind,
  input  logic [1:0] sibling_pos,
  input  logic       parent_collapsed,
  input  logic [7:0] mean_value,
  input  logic [1:0] node_error,
  input  logic       uniform_flag,
  input  logic       end_of_image,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] packed_byte,
  output logic       last_byte
);

  qnbs_pkg::node_t        node;
  qnbs_pkg::pack_state_t  state;
  qnbs_pkg::pack_state_t  state_next;
  qnbs_pkg::pack_result_t result;
  qnbs_pkg::outq_status_t status;
  logic                   accept;

  // Gather the node fields for the packer.
  assign node = '{
    node_kind:        node_kind,
    sibling_pos:      sibling_pos,
    parent_collapsed: parent_collapsed,
    mean_value:       mean_value,
    node_error:       node_error,
    uniform_flag:     uniform_flag,
    end_of_image:     end_of_image
  };

  // Take a node only when the queue can absorb all of its bytes.
  assign in_ready = status.can_load;
  assign accept   = in_valid && in_ready;

  qnbs_pack u_pack (
    .node       (node),
    .state      (state),
    .state_next (state_next),
    .result     (result)
  );

  // Hold the waiting bits and the early-end flag; advance on each transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (accept) begin
      state <= state_next;
    end
  end

  qnbs_outq u_outq (
    .clk         (clk),
    .rst         (rst),
    .load        (accept),
    .result      (result),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .packed_byte (packed_byte),
    .last_byte   (last_byte),
    .status      (status)
  );

`ifndef SYNTH
  // A new node must never overwrite bytes still waiting in the queue.
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    accept |-> (!out_valid || (out_ready && status.level == 2'd1)))
    else $error("node accepted over pending bytes");

  // The final byte of an image is always the last one queued.
  a_last_at_tail: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last_byte) |-> (status.level == 2'd1))
    else $error("last byte not at tail of queue");

  // While an image is closed early no bits may be waiting.
  a_done_empty: assert property (@(posedge clk) disable iff (rst)
    state.stream_done |-> (state.bit_count == '0 && state.bit_accumulator == '0))
    else $error("bits waiting after early end");

  // With no bits waiting the accumulator stays clear.
  a_acc_clean: assert property (@(posedge clk) disable iff (rst)
    (state.bit_count == '0) |-> (state.bit_accumulator == '0))
    else $error("stale accumulator bits");
`endif

endmodule

// ===== hdl/qnbs_pack.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qnbs_pack
// Combinational packer: merges one node's code bits with the waiting bits
// and splits the result into whole bytes plus, on a flush, a padded final byte.
// ----------------------------------------------------------------------------
module qnbs_pack (
  input  qnbs_pkg::node_t       node,
  input  qnbs_pkg::pack_state_t state,
  output qnbs_pkg::pack_state_t state_next,
  output qnbs_pkg::pack_result_t result
);

  logic [qnbs_pkg::FieldBits-1:0] field;
  logic [3:0]                     nbits;
  logic                           ended_now;
  logic                           flush;
  logic [qnbs_pkg::CombBits-1:0]  combined;
  logic [qnbs_pkg::TotalBits-1:0] total;
  logic [qnbs_pkg::AlignBits-1:0] aligned;
  logic [1:0]                     full;
  logic [2:0]                     rem;
  logic [qnbs_pkg::AccBits-1:0]   rem_mask;
  logic                           pad;

  // Select the code bits of this node, right aligned.
  always_comb begin
    field = '0;
    nbits = 4'd0;
    unique case (node.node_kind)
      qnbs_pkg::KIND_ROOT: begin
        if (node.node_error == 2'd0) begin
          field = {node.mean_value, node.node_error, node.uniform_flag};
          nbits = 4'd11;
        end else begin
          field = {1'b0, node.mean_value, node.node_error};
          nbits = 4'd10;
        end
      end
      qnbs_pkg::KIND_INTERIOR: begin
        if (!node.parent_collapsed) begin
          if (node.sibling_pos != qnbs_pkg::LastSibling) begin
            if (node.node_error == 2'd0) begin
              field = {node.mean_value, node.node_error, node.uniform_flag};
              nbits = 4'd11;
            end else begin
              field = {1'b0, node.mean_value, node.node_error};
              nbits = 4'd10;
            end
          end else if (node.node_error == 2'd0) begin
            field = {8'd0, node.node_error, node.uniform_flag};
            nbits = 4'd3;
          end else begin
            field = {9'd0, node.node_error};
            nbits = 4'd2;
          end
        end
      end
      qnbs_pkg::KIND_FINEST: begin
        if (!node.parent_collapsed && node.sibling_pos != qnbs_pkg::LastSibling) begin
          field = {3'd0, node.mean_value};
          nbits = 4'd8;
        end
      end
      default: begin
        field = '0;
        nbits = 4'd0;
      end
    endcase
  end

  assign ended_now = (node.node_kind == qnbs_pkg::KIND_ROOT) &&
                     (node.node_error == 2'd0) && node.uniform_flag;
  assign flush     = ended_now || node.end_of_image;

  always_comb begin
    combined = ({{qnbs_pkg::FieldBits{1'b0}}, state.bit_accumulator} << nbits) |
               {{qnbs_pkg::AccBits{1'b0}}, field};
    total    = qnbs_pkg::TotalBits'(state.bit_count) + qnbs_pkg::TotalBits'(nbits);
    aligned  = {{(qnbs_pkg::AlignBits - qnbs_pkg::CombBits){1'b0}}, combined}
               << (qnbs_pkg::TotalBits'(qnbs_pkg::AlignBits) - total);
    full     = total[4:3];
    rem      = total[2:0];
    rem_mask = qnbs_pkg::AccBits'((8'd1 << rem) - 8'd1);
    pad      = flush && (rem != 3'd0);
  end

  always_comb begin
    result.bytes = {aligned[23:16], aligned[15:8], aligned[7:0]};
    result.count = 2'd0;
    result.last  = 1'b0;
    state_next   = state;
    if (state.stream_done) begin
      // Drop nodes until the image ends.
      if (node.end_of_image) begin
        state_next.stream_done = 1'b0;
      end
    end else begin
      result.count = qnbs_pkg::LevelBits'(full) + qnbs_pkg::LevelBits'(pad);
      result.last  = flush;
      if (flush) begin
        state_next.bit_accumulator = '0;
        state_next.bit_count       = '0;
        state_next.stream_done     = ended_now && !node.end_of_image;
      end else begin
        state_next.bit_accumulator = combined[qnbs_pkg::AccBits-1:0] & rem_mask;
        state_next.bit_count       = rem;
      end
    end
  end

endmodule

// ===== hdl/qnbs_outq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qnbs_outq
// Three-entry byte queue that takes all bytes of one node at once and
// hands them out one per transaction.
// ----------------------------------------------------------------------------
module qnbs_outq (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    load,
  input  qnbs_pkg::pack_result_t  result,
  input  logic                    out_ready,
  output logic                    out_valid,
  output logic [7:0]              packed_byte,
  output logic                    last_byte,
  output qnbs_pkg::outq_status_t  status
);

  logic [qnbs_pkg::MaxBytes-1:0][qnbs_pkg::ByteBits-1:0] data;
  logic [qnbs_pkg::MaxBytes-1:0]                         last;
  logic [qnbs_pkg::LevelBits-1:0]                        level;
  logic                                                  pop;

  assign out_valid       = (level != '0);
  assign pop             = out_valid && out_ready;
  assign packed_byte     = data[0];
  assign last_byte       = last[0];
  assign status.level    = level;
  assign status.can_load = (level == '0) || ((level == 2'd1) && out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      level <= '0;
    end else if (load) begin
      level <= result.count;
    end else if (pop) begin
      level <= level - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      // Head takes the first byte; flag the final one when it ends the image.
      for (int i = 0; i < qnbs_pkg::MaxBytes; i++) begin
        data[i] <= result.bytes[qnbs_pkg::MaxBytes-1-i];
        last[i] <= result.last && (result.count == qnbs_pkg::LevelBits'(i + 1));
      end
    end else if (pop) begin
      for (int i = 0; i < qnbs_pkg::MaxBytes - 1; i++) begin
        data[i] <= data[i+1];
        last[i] <= last[i+1];
      end
      data[qnbs_pkg::MaxBytes-1] <= '0;
      last[qnbs_pkg::MaxBytes-1] <= 1'b0;
    end
  end

endmodule
